FILE: hdl/assert_macros.svh
// Assertion macros for the checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk_sig, rst_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define ASSERT_ALWAYS(label, clk_sig, prop, msg) \
  label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

FILE: hdl/e8ctt_pkg.sv
`timescale 1ns / 1ps

package e8ctt_pkg;

  localparam int LEN_W  = 16;
  localparam int TSZ_W  = 31;
  localparam int CFG_W  = 31;
  localparam int IDX_W  = 2;
  localparam int CNT_W  = 3;

  // Register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_BLOCK_LENGTH     = 2'd0;
  localparam logic [IDX_W-1:0] REG_TRANSLATION_SIZE = 2'd1;

  // Register reset values
  localparam logic [LEN_W-1:0] BLOCK_LENGTH_RST     = 16'd32768;
  localparam logic [TSZ_W-1:0] TRANSLATION_SIZE_RST = 31'd12000000;

  localparam logic [7:0]       E8_OPCODE  = 8'hE8;
  localparam logic [LEN_W-1:0] TAIL_GUARD = 16'd10;

  // Operand hold counter codes
  localparam logic [CNT_W-1:0] HELD_NONE = 3'd0;
  localparam logic [CNT_W-1:0] HELD_ONE  = 3'd1;
  localparam logic [CNT_W-1:0] HELD_FULL = 3'd4;

  // Byte index of the last item of a five-byte run
  localparam logic [CNT_W-1:0] RUN_LAST_IDX = 3'd4;

  // One record handed from the scanner to the serializer
  typedef struct packed {
    logic        is_run;
    logic [31:0] word;
    logic        block_last;
  } rec_t;

endpackage

FILE: hdl/e8ctt_scan.sv
`timescale 1ns / 1ps

module e8ctt_scan import e8ctt_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  output logic             rec_valid,
  input  logic             rec_ready,
  output rec_t             rec
);

  localparam int CW = (POSITION_BITS + 1 > LEN_W) ? POSITION_BITS + 1 : LEN_W;

  logic [LEN_W-1:0]         block_length;
  logic [TSZ_W-1:0]         translation_size;
  logic [POSITION_BITS-1:0] byte_position;
  logic [POSITION_BITS-1:0] opcode_position;
  logic [CNT_W-1:0]         held_count;
  logic [7:0]               held_operand [3];

  logic                     in_accept;
  logic [CW-1:0]            next_ext;
  logic                     block_end;
  logic [POSITION_BITS-1:0] pos_after;
  logic                     open_ok;
  logic                     take_open;
  logic                     emit_single;
  logic                     emit_run;
  logic [1:0]               hold_slot;

  logic [31:0]        raw;
  logic signed [33:0] rel;
  logic signed [33:0] ofs;
  logic signed [33:0] tsz;
  logic signed [33:0] sum;
  logic signed [33:0] diff;
  logic               in_range;
  logic               sum_lt;
  logic [31:0]        res;

  assign in_ready  = !rec_valid || rec_ready;
  assign in_accept = in_valid && in_ready;

  // Position advance and block end
  assign next_ext  = CW'(byte_position) + CW'(1);
  assign block_end = next_ext >= CW'(block_length);
  assign pos_after = block_end ? '0 : next_ext[POSITION_BITS-1:0];

  // An opcode may open a hold only clear of the block tail
  assign open_ok = (block_length > TAIL_GUARD) &&
                   (CW'(byte_position) < CW'(block_length - TAIL_GUARD));

  assign take_open   = (held_count == HELD_NONE) && (data_byte == E8_OPCODE) && open_ok;
  assign emit_single = (held_count == HELD_NONE) && !take_open;
  assign emit_run    = (held_count == HELD_FULL);
  assign hold_slot   = held_count[1:0] - 2'd1;

  // Call offset translation on the fourth operand byte
  assign raw      = {data_byte, held_operand[2], held_operand[1], held_operand[0]};
  assign rel      = {{2{raw[31]}}, raw};
  assign ofs      = {{(34 - POSITION_BITS){1'b0}}, opcode_position};
  assign tsz      = {3'b000, translation_size};
  assign sum      = rel + ofs;
  assign diff     = rel - tsz;
  assign in_range = !sum[33] && diff[33];
  assign sum_lt   = sum < tsz;
  assign res      = !in_range ? raw : (sum_lt ? sum[31:0] : diff[31:0]);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      block_length     <= BLOCK_LENGTH_RST;
      translation_size <= TRANSLATION_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BLOCK_LENGTH:     block_length     <= cfg_data[LEN_W-1:0];
        REG_TRANSLATION_SIZE: translation_size <= cfg_data[TSZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Scan state and record valid
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      opcode_position <= '0;
      held_count      <= HELD_NONE;
      rec_valid       <= 1'b0;
    end else begin
      if (rec_ready) begin
        rec_valid <= 1'b0;
      end
      if (in_accept) begin
        byte_position <= pos_after;
        if (take_open) begin
          opcode_position <= byte_position;
          held_count      <= HELD_ONE;
        end else if (emit_run) begin
          held_count <= HELD_NONE;
        end else if (!emit_single) begin
          held_count <= held_count + 3'd1;
        end
        if (emit_single || emit_run) begin
          rec_valid <= 1'b1;
        end
      end
    end
  end

  // Operand bytes, no reset
  always_ff @(posedge clk) begin
    if (in_accept && !emit_single && !emit_run && !take_open) begin
      held_operand[hold_slot] <= data_byte;
    end
  end

  // Record payload, no reset
  always_ff @(posedge clk) begin
    if (in_accept && (emit_single || emit_run)) begin
      rec.is_run     <= emit_run;
      rec.word       <= emit_run ? res : {24'd0, data_byte};
      rec.block_last <= block_end;
    end
  end

endmodule

FILE: hdl/e8ctt_serial.sv
`timescale 1ns / 1ps

module e8ctt_serial import e8ctt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rec_valid,
  output logic       rec_ready,
  input  rec_t       rec,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_last,
  output logic       block_last
);

  rec_t             cur;
  logic [CNT_W-1:0] idx;
  logic             last_of;
  logic             load;

  assign last_of   = !cur.is_run || (idx == RUN_LAST_IDX);
  assign rec_ready = !out_valid || (out_ready && last_of);
  assign load      = rec_ready;

  // Byte selection within the current record
  always_comb begin
    if (!cur.is_run) begin
      out_byte = cur.word[7:0];
    end else begin
      case (idx)
        3'd0:    out_byte = E8_OPCODE;
        3'd1:    out_byte = cur.word[7:0];
        3'd2:    out_byte = cur.word[15:8];
        3'd3:    out_byte = cur.word[23:16];
        default: out_byte = cur.word[31:24];
      endcase
    end
  end

  assign run_last   = last_of;
  assign block_last = last_of && cur.block_last;

  // Output valid and byte index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      out_valid <= rec_valid;
      idx       <= '0;
    end else if (out_valid && out_ready) begin
      idx <= idx + 3'd1;
    end
  end

  // Current record, no reset
  always_ff @(posedge clk) begin
    if (load) begin
      cur <= rec;
    end
  end

endmodule

FILE: hdl/e8_call_target_translator.sv
`timescale 1ns / 1ps
// Path: a byte's first result is registered in the scanner's record slot and then in
// the serializer's current record, from which it is offered.
// Throughput: one input byte per cycle while the output keeps up; the output port moves
// one byte per cycle while out_ready is high, so a translated call run of five can hold
// back the input, bounded by the single record slot between scanner and serializer.
// Reset (rst, synchronous, active high) clears position and hold state and
// restores register defaults; held operand bytes are not cleared.

module e8_call_target_translator import e8ctt_pkg::*; #(
  parameter int POSITION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       data_byte,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             run_last,
  output logic             block_last
);

  logic rec_valid;
  logic rec_ready;
  rec_t rec;

  // Scanner: position count, operand hold, offset translation
  e8ctt_scan #(
    .POSITION_BITS(POSITION_BITS)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .data_byte (data_byte),
    .rec_valid (rec_valid),
    .rec_ready (rec_ready),
    .rec       (rec)
  );

  // Serializer: one output byte per cycle while out_ready is high
  e8ctt_serial u_serial (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec        (rec),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .block_last (block_last)
  );

endmodule

FILE: hdl/e8ctt_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module e8ctt_checker import e8ctt_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       block_last
);

  logic prev_last;

  // Tracks whether the last delivered item closed its run
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_last <= 1'b1;
    end else if (out_valid && out_ready) begin
      prev_last <= run_last;
    end
  end

  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte), "stalled output item changed")
  `ASSERT_CLK(a_run_head, clk, rst, out_valid && out_ready && prev_last && !run_last |-> out_byte == E8_OPCODE, "run does not open with the opcode")
  `ASSERT_CLK(a_mid_run, clk, rst, out_valid && !run_last |-> !block_last, "block end inside a run")
  `ASSERT_ALWAYS(a_stall_cause, clk, !in_ready |-> out_valid, "input stalled with no output pending")

endmodule

bind e8_call_target_translator e8ctt_checker u_e8ctt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_byte   (out_byte),
  .run_last   (run_last),
  .block_last (block_last)
);

FILE: tb/sv/e8_call_target_translator_tb.sv
`timescale 1ns / 1ps

module e8_call_target_translator_tb;
  import e8ctt_pkg::*;

  // Indexes past the two registers; writes there must be ignored
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 2'd3;

  localparam int SETTLE_CYCLES   = 6;
  localparam int STALL_LIMIT     = 4000;
  localparam int HOLD_OFF_CYCLES = 100;
  localparam int PHASE_ITEMS     = 45;
  localparam int IDLE_PCT        = 38;

  // How the call offset is picked relative to the opcode position and translation size
  typedef enum int {
    OFF_LOW_EDGE, OFF_BELOW_LOW, OFF_ADD_EDGE, OFF_SUB_EDGE, OFF_TOP_IN, OFF_TOP_OUT,
    OFF_ZERO, OFF_MAX_POS, OFF_MIN_NEG, OFF_IN_RANGE, OFF_ANY
  } off_kind_t;

  typedef struct packed {
    logic [7:0] value;
    logic       run_end;
    logic       blk_end;
  } out_rec_t;

  // Tracks the translator state and the bytes it still owes on its output
  class call_xlat_board;
    logic [LEN_W-1:0] blk_len;
    logic [TSZ_W-1:0] tsize;
    logic [LEN_W-1:0] pos;
    logic [LEN_W-1:0] op_pos;
    logic [CNT_W-1:0] held_cnt;
    logic [7:0]       held [3];
    out_rec_t         pending_out [$];
    int               fails;

    function new();
      blk_len  = BLOCK_LENGTH_RST;
      tsize    = TRANSLATION_SIZE_RST;
      pos      = '0;
      op_pos   = '0;
      held_cnt = HELD_NONE;
      fails    = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_BLOCK_LENGTH:     blk_len = data[LEN_W-1:0];
        REG_TRANSLATION_SIZE: tsize = data[TSZ_W-1:0];
        default: ;
      endcase
    endfunction

    // Advance the byte position; returns 1 when this byte closes the block
    function logic step_position();
      logic [31:0] nxt;
      nxt = pos + 32'd1;
      if (nxt >= blk_len) begin
        pos = '0;
        return 1'b1;
      end
      pos = nxt[LEN_W-1:0];
      return 1'b0;
    endfunction

    function logic [31:0] translate_target(logic [31:0] raw);
      longint rel, i, ts, abs_off;
      rel = $signed(raw);
      i   = op_pos;
      ts  = tsize;
      if (rel >= -i && rel < ts) begin
        abs_off = (rel < ts - i) ? rel + i : rel - ts;
        return abs_off[31:0];
      end
      return raw;
    endfunction

    // Called for every accepted input byte
    function void predict_byte(logic [7:0] b);
      logic [31:0] res;
      logic        ends;
      if (held_cnt == HELD_NONE) begin
        if (b == E8_OPCODE && blk_len > TAIL_GUARD && pos < blk_len - TAIL_GUARD) begin
          op_pos   = pos;
          held_cnt = HELD_ONE;
          void'(step_position());
          return;
        end
        ends = step_position();
        pending_out.push_back(out_rec_t'{b, 1'b1, ends});
        return;
      end
      if (held_cnt < HELD_FULL) begin
        held[held_cnt - 1] = b;
        held_cnt++;
        void'(step_position());
        return;
      end
      // fourth operand byte: the whole run of five leaves now
      res      = translate_target({b, held[2], held[1], held[0]});
      held_cnt = HELD_NONE;
      ends     = step_position();
      pending_out.push_back(out_rec_t'{E8_OPCODE, 1'b0, 1'b0});
      for (int k = 0; k < 4; k++) begin
        pending_out.push_back(out_rec_t'{res[8*k +: 8], k == 3, (k == 3) && ends});
      end
    endfunction

    function void compare_out(logic [7:0] b, logic rl, logic bl);
      out_rec_t e;
      if (pending_out.size() == 0) begin
        fails++;
        $display("%0t: unexpected item out_byte %02h run_last %0b block_last %0b",
                 $time, b, rl, bl);
        return;
      end
      e = pending_out.pop_front();
      if (b !== e.value) begin
        fails++;
        $display("%0t: out_byte expected %02h actual %02h", $time, e.value, b);
      end
      if (rl !== e.run_end) begin
        fails++;
        $display("%0t: run_last expected %0b actual %0b", $time, e.run_end, rl);
      end
      if (bl !== e.blk_end) begin
        fails++;
        $display("%0t: block_last expected %0b actual %0b", $time, e.blk_end, bl);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             in_valid;
  logic             in_ready;
  logic [7:0]       data_byte;
  logic             out_valid;
  logic             out_ready;
  logic [7:0]       out_byte;
  logic             run_last;
  logic             block_last;

  call_xlat_board xlat = new();
  bit             no_idle = 1'b0;
  bit             hold_req = 1'b0;
  int             hold_left = 0;
  int             quiet_cycles = 0;

  e8_call_target_translator DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_byte   (out_byte),
    .run_last   (run_last),
    .block_last (block_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one byte, idling at random first, and wait for it to be taken
  task automatic push_byte(input logic [7:0] b);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid  = 1'b0;
      data_byte = 8'($urandom);
      @(negedge clk);
    end
    in_valid  = 1'b1;
    data_byte = b;
    do @(posedge clk); while (!in_ready);
    xlat.predict_byte(b);
  endtask

  task automatic push_call_raw(input logic [31:0] raw);
    push_byte(E8_OPCODE);
    for (int k = 0; k < 4; k++) push_byte(raw[8*k +: 8]);
  endtask

  // Opcode plus offset of the chosen kind: window edges, extremes, zero or random
  task automatic push_call(input off_kind_t kind);
    longint i, ts, rel, span;
    i  = xlat.pos;
    ts = xlat.tsize;
    case (kind)
      OFF_LOW_EDGE:  rel = -i;
      OFF_BELOW_LOW: rel = -i - 1;
      OFF_ADD_EDGE:  rel = ts - i - 1;
      OFF_SUB_EDGE:  rel = ts - i;
      OFF_TOP_IN:    rel = ts - 1;
      OFF_TOP_OUT:   rel = ts;
      OFF_ZERO:      rel = 0;
      OFF_MAX_POS:   rel = 64'h7FFF_FFFF;
      OFF_MIN_NEG:   rel = -64'sh8000_0000;
      OFF_IN_RANGE: begin
        span = ts + i;
        rel  = (span > 0) ? -i + longint'($urandom) % span : 0;
      end
      default:       rel = $signed($urandom);
    endcase
    push_call_raw(rel[31:0]);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    xlat.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Stop offering, wait for every owed byte, then idle before the next step
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (xlat.pending_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input int blen, input int tsz);
    int   sent;
    logic [7:0] b;
    drain();
    write_reg(REG_BLOCK_LENGTH, CFG_W'(blen));
    write_reg(REG_TRANSLATION_SIZE, CFG_W'(tsz));
    sent = 0;
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(99) < 55) begin
        push_call(off_kind_t'(($urandom_range(12) > OFF_ANY) ? OFF_ANY : $urandom_range(OFF_ANY)));
        sent += 5;
      end else begin
        b = ($urandom_range(7) == 0) ? E8_OPCODE : 8'($urandom);
        push_byte(b);
        sent++;
      end
    end
  endtask

  // Output side: random backpressure, one long hold-off on request
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
      @(posedge clk);
      if (!rst && out_valid && out_ready) xlat.compare_out(out_byte, run_last, block_last);
    end
  end

  // Watchdog: too long with no item moving on either side
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = REG_BLOCK_LENGTH;
    cfg_data  = '0;
    in_valid  = 1'b0;
    data_byte = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: 16-byte blocks, so opcodes open a hold only at positions 0..5
    write_reg(REG_BLOCK_LENGTH, CFG_W'(16));
    write_reg(REG_TRANSLATION_SIZE, CFG_W'(100));
    write_reg(REG_SPARE_LO, '1);
    write_reg(REG_SPARE_HI, CFG_W'(3));
    push_call(OFF_BELOW_LOW);        // offset just below -i stays as is
    push_call(OFF_SUB_EDGE);         // last opening position, offset wraps down
    push_byte(E8_OPCODE);            // inside the tail guard: passes through
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'h7F);
    push_byte(8'h80);
    push_byte(8'h01);                // closes the block
    push_call_raw({4{E8_OPCODE}});   // operand bytes are not scanned for opcodes
    // block length changes while a hold is open
    push_byte(E8_OPCODE);
    push_byte(8'h10);
    push_byte(8'h00);
    drain();
    write_reg(REG_BLOCK_LENGTH, CFG_W'(10));
    push_byte(8'h00);
    push_byte(8'h00);

    // Random phases over several settings
    run_phase(16, 100);
    hold_req = 1'b1;
    run_phase(40, 12000000);
    run_phase(11, 0);
    no_idle = 1'b1;
    run_phase(23, 20);
    no_idle = 1'b0;
    run_phase(10, 5000);
    run_phase(0, 7);
    run_phase(65535, 32'h7FFF_FFFF);
    run_phase(300, 1);

    drain();
    if (xlat.fails == 0 && xlat.pending_out.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/e8ctt_pkg.sv
hdl/e8ctt_scan.sv
hdl/e8ctt_serial.sv
hdl/e8_call_target_translator.sv
hdl/e8ctt_checker.sv
tb/sv/e8_call_target_translator_tb.sv
